// ===== rtl/core/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and codes for the bounded multiset store: operation and
// status codes, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int unsigned IN_VALUE_W = 16;  // value / data_out port width
    localparam int unsigned RND_W      = 16;  // random word width
    localparam int unsigned IDX_W      = 6;   // slot_index width
    localparam int unsigned CNT_OUT_W  = 7;   // count port width

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_DRAW   = 3'd2,
        OP_QUERY  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_LAST,
        RD_REM,
        RD_IDX
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_INSERT,
        WR_MOVE,
        WR_MARK
    } t_wr_sel;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_RDATA,
        DSEL_HOLD
    } t_dsel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DIV,
        S_DRAW_GRAB,
        S_MOVE,
        S_MARK,
        S_READ_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    scan_start;
        logic    scan_step;
        logic    pos_from_hit;
        logic    pos_from_rem;
        logic    div_start;
        logic    hold_capture;
        logic    finish;
        t_status status;
        logic    found;
        t_dsel   data_sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic idx_ok;
        logic hit;
        logic scan_done;
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/core/bms_modu.sv =====
// ----------------------------------------------------------------------------
// bms_modu
// Iterative unsigned remainder: dividend mod divisor, one quotient bit per
// cycle (restoring). o_done pulses for one cycle when o_rem is valid.
// ----------------------------------------------------------------------------
module bms_modu #(
    parameter int unsigned DIV_W = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [bms_pkg::RND_W-1:0]          i_dividend,
    input  logic [DIV_W-1:0]                   i_divisor,
    output logic                               o_done,
    output logic [DIV_W-1:0]                   o_rem
);

    localparam int unsigned ITER_W = $clog2(bms_pkg::RND_W + 1);

    logic [DIV_W-1:0]          r_rem,   n_rem;
    logic [bms_pkg::RND_W-1:0] r_shift, n_shift;
    logic [ITER_W-1:0]         r_iter,  n_iter;
    logic                      r_run,   n_run;
    logic                      r_done,  n_done;
    logic [DIV_W:0]            trial;

    always_comb begin
        n_rem   = r_rem;
        n_shift = r_shift;
        n_iter  = r_iter;
        n_run   = r_run;
        n_done  = 1'b0;
        trial   = {r_rem, r_shift[bms_pkg::RND_W-1]};
        if (i_start) begin
            n_rem   = '0;
            n_shift = i_dividend;
            n_iter  = ITER_W'(bms_pkg::RND_W);
            n_run   = 1'b1;
        end else if (r_run) begin
            // partial remainder stays below the divisor, so one subtract is enough
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = DIV_W'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[DIV_W-1:0];
            end
            n_shift = {r_shift[bms_pkg::RND_W-2:0], 1'b0};
            n_iter  = r_iter - 1'b1;
            if (r_iter == ITER_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_shift <= n_shift;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/bms_dpath.sv =====
// ----------------------------------------------------------------------------
// bms_dpath
// Datapath: slot memory (one write, one registered read port), entry count,
// fill mark, scan pointer with compare stage, remainder unit and result regs.
// ----------------------------------------------------------------------------
module bms_dpath #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bms_pkg::t_cmd                         i_cmd,
    output bms_pkg::t_stat                        o_stat,
    input  logic [2:0]                            i_op,
    input  logic signed [bms_pkg::IN_VALUE_W-1:0] i_value,
    input  logic [bms_pkg::RND_W-1:0]             i_random_word,
    input  logic [bms_pkg::IDX_W-1:0]             i_slot_index,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic                                  o_found,
    output logic signed [bms_pkg::IN_VALUE_W-1:0] o_data_out,
    output logic [bms_pkg::CNT_OUT_W-1:0]         o_count,
    output logic                                  o_is_empty
);

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMP_W  = (CNT_W > bms_pkg::IDX_W) ? CNT_W : bms_pkg::IDX_W;
    localparam int unsigned OUT_W  = (CNT_W > bms_pkg::CNT_OUT_W) ? CNT_W : bms_pkg::CNT_OUT_W;

    logic signed [VALUE_BITS-1:0] mem [CAPACITY];

    // operation latch
    bms_pkg::t_op                r_op;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [bms_pkg::RND_W-1:0]   r_rnd;
    logic [CMP_W-1:0]            r_idx;

    // bag state; r_hwm = highest count ever reached, slots at or above it are unwritten
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_hwm;

    // scan pipeline
    logic [CNT_W-1:0]            r_scan_addr;
    logic                        r_cmp_valid;
    logic [ADDR_W-1:0]           r_cmp_idx;

    logic [ADDR_W-1:0]           r_pos;
    logic signed [VALUE_BITS-1:0] r_rdata;
    logic signed [VALUE_BITS-1:0] r_hold;

    // result regs
    logic                        r_valid;
    bms_pkg::t_status            r_res_status;
    logic                        r_res_found;
    logic signed [VALUE_BITS-1:0] r_res_data;

    logic [ADDR_W-1:0]           last_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic                        div_done;
    logic [CNT_W-1:0]            div_rem;
    logic [OUT_W-1:0]            count_ext;

    bms_modu #(
        .DIV_W (CNT_W)
    ) u_modu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign last_addr = ADDR_W'(r_count - 1'b1);

    always_comb begin
        case (i_cmd.rd_sel)
            bms_pkg::RD_SCAN: rd_addr = r_scan_addr[ADDR_W-1:0];
            bms_pkg::RD_LAST: rd_addr = last_addr;
            bms_pkg::RD_REM:  rd_addr = div_rem[ADDR_W-1:0];
            default:          rd_addr = r_idx[ADDR_W-1:0];
        endcase
        case (i_cmd.wr_sel)
            bms_pkg::WR_INSERT: begin
                wr_addr = r_count[ADDR_W-1:0];
                wr_data = r_value;
            end
            bms_pkg::WR_MOVE: begin
                wr_addr = r_pos;
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = last_addr;
                wr_data = '1;   // removal marker
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hwm       <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
            r_op        <= bms_pkg::OP_INSERT;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_op <= bms_pkg::t_op'(i_op);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
                if (r_count == r_hwm) begin
                    r_hwm <= r_hwm + 1'b1;
                end
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_cmp_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_valid <= (r_scan_addr < r_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= VALUE_BITS'(i_value);
            r_rnd   <= i_random_word;
            r_idx   <= CMP_W'(i_slot_index);
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + 1'b1;
            r_cmp_idx   <= r_scan_addr[ADDR_W-1:0];
        end
        if (i_cmd.pos_from_hit) begin
            r_pos <= r_cmp_idx;
        end else if (i_cmd.pos_from_rem) begin
            r_pos <= div_rem[ADDR_W-1:0];
        end
        if (i_cmd.hold_capture) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.finish) begin
            r_res_status <= i_cmd.status;
            r_res_found  <= i_cmd.found;
            case (i_cmd.data_sel)
                bms_pkg::DSEL_RDATA: r_res_data <= r_rdata;
                bms_pkg::DSEL_HOLD:  r_res_data <= r_hold;
                default:             r_res_data <= '0;
            endcase
        end
    end

    // the last stored entry is compared in the cycle the pointer reaches the count
    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.idx_ok    = (r_idx < CMP_W'(r_hwm));
    assign o_stat.hit       = r_cmp_valid && (r_rdata == r_value);
    assign o_stat.scan_done = (r_scan_addr >= r_count);
    assign o_stat.div_done  = div_done;

    assign count_ext  = OUT_W'(r_count);
    assign o_valid    = r_valid;
    assign o_status   = r_res_status;
    assign o_found    = r_res_found;
    assign o_data_out = bms_pkg::IN_VALUE_W'(r_res_data);
    assign o_count    = count_ext[bms_pkg::CNT_OUT_W-1:0];
    assign o_is_empty = (r_count == '0);

endmodule

// ===== rtl/core/bms_ctrl.sv =====
// ----------------------------------------------------------------------------
// bms_ctrl
// Controller FSM: dispatches one operation at a time and sequences the scan,
// the remainder step and the swap-remove through command beats.
// ----------------------------------------------------------------------------
module bms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bms_pkg::t_stat i_stat,
    output bms_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    bms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bms_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = bms_pkg::S_DISPATCH;
                end
            end
            bms_pkg::S_DISPATCH: begin
                n_state = bms_pkg::S_IDLE;
                unique case (i_stat.op) inside
                    bms_pkg::OP_INSERT: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.status = bms_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = bms_pkg::WR_INSERT;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    bms_pkg::OP_REMOVE, bms_pkg::OP_QUERY: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = (i_stat.op == bms_pkg::OP_REMOVE) ?
                                           bms_pkg::ST_EMPTY : bms_pkg::ST_OK;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = bms_pkg::S_SCAN;
                        end
                    end
                    bms_pkg::OP_DRAW: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = bms_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = bms_pkg::S_DIV;
                        end
                    end
                    bms_pkg::OP_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = bms_pkg::RD_IDX;
                            n_state      = bms_pkg::S_READ_DONE;
                        end else begin
                            // never-written slot (or beyond capacity) reads zero
                            o_cmd.finish = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            bms_pkg::S_SCAN: begin
                if (i_stat.hit) begin
                    if (i_stat.op == bms_pkg::OP_REMOVE) begin
                        o_cmd.pos_from_hit = 1'b1;
                        o_cmd.rd_en        = 1'b1;
                        o_cmd.rd_sel       = bms_pkg::RD_LAST;
                        n_state            = bms_pkg::S_MOVE;
                    end else begin
                        o_cmd.finish = 1'b1;
                        o_cmd.found  = 1'b1;
                        n_state      = bms_pkg::S_IDLE;
                    end
                end else if (i_stat.scan_done) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = (i_stat.op == bms_pkg::OP_REMOVE) ?
                                   bms_pkg::ST_NOT_FOUND : bms_pkg::ST_OK;
                    n_state      = bms_pkg::S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = bms_pkg::RD_SCAN;
                end
            end
            bms_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.pos_from_rem = 1'b1;
                    o_cmd.rd_en        = 1'b1;
                    o_cmd.rd_sel       = bms_pkg::RD_REM;
                    n_state            = bms_pkg::S_DRAW_GRAB;
                end
            end
            bms_pkg::S_DRAW_GRAB: begin
                o_cmd.hold_capture = 1'b1;
                o_cmd.rd_en        = 1'b1;
                o_cmd.rd_sel       = bms_pkg::RD_LAST;
                n_state            = bms_pkg::S_MOVE;
            end
            bms_pkg::S_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bms_pkg::WR_MOVE;
                n_state      = bms_pkg::S_MARK;
            end
            bms_pkg::S_MARK: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = bms_pkg::WR_MARK;
                o_cmd.cnt_dec  = 1'b1;
                o_cmd.finish   = 1'b1;
                o_cmd.data_sel = (i_stat.op == bms_pkg::OP_DRAW) ?
                                 bms_pkg::DSEL_HOLD : bms_pkg::DSEL_ZERO;
                n_state        = bms_pkg::S_IDLE;
            end
            bms_pkg::S_READ_DONE: begin
                o_cmd.finish   = 1'b1;
                o_cmd.data_sel = bms_pkg::DSEL_RDATA;
                n_state        = bms_pkg::S_IDLE;
            end
            default: begin
                n_state = bms_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != bms_pkg::S_IDLE);

endmodule

// ===== rtl/core/bounded_multiset_store.sv =====
// ----------------------------------------------------------------------------
// bounded_multiset_store
// Fixed-capacity unordered bag of signed values with insert, swap-remove,
// random draw, membership query and slot read.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op/value/random_word/slot_index with start high;
//   the beat is taken on a clock edge where start is high and busy is low.
//   busy stays high until the result has been issued.
//   Result channel: o_valid pulses for one cycle with status, found,
//   data_out, count and is_empty; the receiver cannot stall it, so it must
//   capture the beat in that cycle.
// Result path by operation (from accept to o_valid high):
//   insert, empty/full errors, unknown op,
//   read of a never-written slot          : finished in the dispatch state
//   read of a written slot                : dispatch, then the registered slot read
//   query, remove of an absent value      : set by the one-slot-per-cycle scan
//   remove of a present value             : scan plus the two swap writes
//   draw                                  : set by the 16-step remainder unit
//   A new command may be taken in the cycle o_valid is high.
// Reset (synchronous, active low) empties the bag; slots that were never
// written read as zero through a fill mark, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_multiset_store #(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            i_op,
    input  logic signed [bms_pkg::IN_VALUE_W-1:0] i_value,
    input  logic [bms_pkg::RND_W-1:0]             i_random_word,
    input  logic [bms_pkg::IDX_W-1:0]             i_slot_index,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic                                  o_found,
    output logic signed [bms_pkg::IN_VALUE_W-1:0] o_data_out,
    output logic [bms_pkg::CNT_OUT_W-1:0]         o_count,
    output logic                                  o_is_empty
);

    bms_pkg::t_cmd  cmd;
    bms_pkg::t_stat stat;

    // controller: sequencing only, no payload
    bms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: slot memory, count, scan, remainder unit, result regs
    bms_dpath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_random_word (i_random_word),
        .i_slot_index  (i_slot_index),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_data_out    (o_data_out),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

endmodule
